FILE: hdl/txpf_pkg.sv
// Package for the transmit packet framer: op codes, framing constants,
// the input item struct and the byte-parallel CRC5 and CRC16 update functions.
// Depends on nothing.
`timescale 1ns / 1ps

package txpf_pkg;

    typedef enum logic [1:0] {
        OP_CMD  = 2'd0,
        OP_JOB  = 2'd1,
        OP_DATA = 2'd2
    } t_op;

    typedef enum logic {
        REG_CMD_TYPE = 1'b0,
        REG_JOB_HDR  = 1'b1
    } t_reg_idx;

    localparam logic [7:0] PRE0              = 8'h55;
    localparam logic [7:0] PRE1              = 8'hAA;
    localparam int         JOB_PAYLOAD_BYTES = 82;
    localparam logic [7:0] JOB_PAYLOAD_CNT   = 8'(JOB_PAYLOAD_BYTES);
    localparam logic [7:0] JOB_LEN_BYTE      = 8'(JOB_PAYLOAD_BYTES + 4);
    localparam logic [7:0] CMD_LEN_EXTRA     = 8'd3;
    localparam logic [7:0] CMD_TYPE_RESET    = 8'd64;
    localparam logic [7:0] JOB_HDR_RESET     = 8'd33;

    localparam logic [4:0]  CRC5_INIT  = 5'h1F;
    localparam logic [4:0]  CRC5_POLY  = 5'h05;
    localparam logic [15:0] CRC16_INIT = 16'hFFFF;
    localparam logic [15:0] CRC16_POLY = 16'h1021;

    localparam int MAX_BEATS = 5;
    localparam int CNT_W     = $clog2(MAX_BEATS + 1);

    typedef logic [CNT_W-1:0] t_cnt;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] payload_length;
        logic [7:0] command_code;
        logic [7:0] group_bits;
        logic [1:0] op;
    } t_in_item;

    function automatic logic [4:0] crc5_byte(input logic [4:0] crc, input logic [7:0] b);
        logic [4:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[4] ^ b[i];
            c  = {c[3:0], 1'b0} ^ (fb ? CRC5_POLY : 5'h00);
        end
        return c;
    endfunction

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = {c[14:0], 1'b0} ^ (c[15] ? CRC16_POLY : 16'h0000);
        end
        return c;
    endfunction

endpackage

FILE: hdl/tx_packet_framer_crc5_crc16.sv
// Transmit packet framer top level: input register, framing and CRC logic,
// a five-byte result buffer drained one byte per cycle while i_m_tready is high.
// Depends on txpf_pkg.
`timescale 1ns / 1ps

// Request in, bytes out. A start-command request yields preamble 0x55 0xAA,
// header (type bits | group | command), length (payload + 3) and, for an empty
// payload, the CRC5 byte at once. A start-job request yields preamble, the job
// header byte and length 86, then 82 payload requests follow and the packet
// ends with CRC-16/CCITT-FALSE, high byte first. A payload request echoes its
// byte, plus the closing CRC after the last one; outside a packet it yields
// nothing. A request waits in the input register and is then turned into
// up to five bytes in the result buffer, which sends one byte per cycle
// while i_m_tready is high. Payload requests flow at one per cycle while the
// receiver is ready; a start request loads 4 or 5 bytes into the buffer, a
// closing payload request 2 (command) or 3 (job). The first byte leaves via
// the input register and the result buffer. tlast marks the final CRC byte.
module tx_packet_framer_crc5_crc16
    import txpf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [1:0] op, [9:2] group_bits, [17:10] command_code, [25:18] payload_length,
    // [33:26] data_byte, [39:34] zero
    input  logic [39:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] tx_byte
    output logic [7:0]  o_m_tdata,
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic [7:0]  r_cmd_type;
    logic [7:0]  r_job_hdr;

    logic        r_in_valid;
    t_in_item    r_in;

    logic        r_open;
    logic        r_is_job;
    logic [7:0]  r_rem;
    logic [15:0] r_crc;
    logic        n_open;
    logic        n_is_job;
    logic [7:0]  n_rem;
    logic [15:0] n_crc;

    logic [7:0]  r_buf [MAX_BEATS];
    logic [7:0]  n_buf [MAX_BEATS];
    t_cnt        r_cnt;
    t_cnt        n_cnt;
    logic        r_eop;
    logic        n_eop;

    logic        buf_free;
    logic        advance;

    logic [7:0]  cmd_hdr;
    logic [7:0]  cmd_len;
    logic [4:0]  cmd_crc;
    logic [15:0] job_crc;
    logic [7:0]  rem_dec;
    logic [15:0] data_crc;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_type <= CMD_TYPE_RESET;
            r_job_hdr  <= JOB_HDR_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_CMD_TYPE: r_cmd_type <= i_cfg_data;
                REG_JOB_HDR:  r_job_hdr  <= i_cfg_data;
                default:      r_cmd_type <= r_cmd_type;
            endcase
        end
    end

    assign buf_free   = (r_cnt == '0) || ((r_cnt == t_cnt'(1)) && i_m_tready);
    assign advance    = r_in_valid && buf_free;
    assign o_s_tready = !r_in_valid || buf_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in <= t_in_item'(i_s_tdata[33:0]);
        end
    end

    assign cmd_hdr  = r_cmd_type | r_in.group_bits | r_in.command_code;
    assign cmd_len  = r_in.payload_length + CMD_LEN_EXTRA;
    assign cmd_crc  = crc5_byte(crc5_byte(CRC5_INIT, cmd_hdr), cmd_len);
    assign job_crc  = crc16_byte(crc16_byte(CRC16_INIT, r_job_hdr), JOB_LEN_BYTE);
    assign rem_dec  = r_rem - 8'd1;
    assign data_crc = r_is_job ? crc16_byte(r_crc, r_in.data_byte)
                               : {11'd0, crc5_byte(r_crc[4:0], r_in.data_byte)};

    always_comb begin
        n_open   = r_open;
        n_is_job = r_is_job;
        n_rem    = r_rem;
        n_crc    = r_crc;
        n_cnt    = r_cnt;
        n_eop    = r_eop;
        for (int i = 0; i < MAX_BEATS; i++) begin
            n_buf[i] = r_buf[i];
        end
        if (o_m_tvalid && i_m_tready) begin
            for (int i = 0; i < MAX_BEATS - 1; i++) begin
                n_buf[i] = r_buf[i+1];
            end
            n_cnt = r_cnt - t_cnt'(1);
        end
        if (advance) begin
            n_cnt = '0;
            n_eop = 1'b0;
            unique case (t_op'(r_in.op))
                OP_CMD: begin
                    n_is_job = 1'b0;
                    n_rem    = r_in.payload_length;
                    n_crc    = {11'd0, cmd_crc};
                    n_buf[0] = PRE0;
                    n_buf[1] = PRE1;
                    n_buf[2] = cmd_hdr;
                    n_buf[3] = cmd_len;
                    n_buf[4] = {3'd0, cmd_crc};
                    if (r_in.payload_length == 8'd0) begin
                        n_open = 1'b0;
                        n_cnt  = t_cnt'(5);
                        n_eop  = 1'b1;
                    end else begin
                        n_open = 1'b1;
                        n_cnt  = t_cnt'(4);
                    end
                end
                OP_JOB: begin
                    n_is_job = 1'b1;
                    n_open   = 1'b1;
                    n_rem    = JOB_PAYLOAD_CNT;
                    n_crc    = job_crc;
                    n_buf[0] = PRE0;
                    n_buf[1] = PRE1;
                    n_buf[2] = r_job_hdr;
                    n_buf[3] = JOB_LEN_BYTE;
                    n_cnt    = t_cnt'(4);
                end
                OP_DATA: begin
                    if (r_open) begin
                        n_buf[0] = r_in.data_byte;
                        n_crc    = data_crc;
                        n_rem    = rem_dec;
                        n_cnt    = t_cnt'(1);
                        if (rem_dec == 8'd0) begin
                            n_open = 1'b0;
                            n_eop  = 1'b1;
                            if (r_is_job) begin
                                n_buf[1] = data_crc[15:8];
                                n_buf[2] = data_crc[7:0];
                                n_cnt    = t_cnt'(3);
                            end else begin
                                n_buf[1] = {3'd0, data_crc[4:0]};
                                n_cnt    = t_cnt'(2);
                            end
                        end
                    end
                end
                default: begin
                    n_cnt = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open   <= 1'b0;
            r_is_job <= 1'b0;
            r_rem    <= 8'd0;
            r_crc    <= 16'd0;
            r_cnt    <= '0;
            r_eop    <= 1'b0;
        end else begin
            r_open   <= n_open;
            r_is_job <= n_is_job;
            r_rem    <= n_rem;
            r_crc    <= n_crc;
            r_cnt    <= n_cnt;
            r_eop    <= n_eop;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_BEATS; i++) begin
            r_buf[i] <= n_buf[i];
        end
    end

    assign o_m_tvalid = (r_cnt != '0);
    assign o_m_tdata  = r_buf[0];
    assign o_m_tlast  = r_eop && (r_cnt == t_cnt'(1));

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= t_cnt'(MAX_BEATS))
        else $error("result buffer count out of range");

    a_open_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open |-> (r_rem != 8'd0))
        else $error("open packet with no bytes remaining");

    a_job_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_open && r_is_job) |-> (r_rem <= JOB_PAYLOAD_CNT))
        else $error("job byte count above payload size");

    a_job_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_in.op == OP_JOB)) |=>
            ((r_cnt == t_cnt'(4)) && (r_buf[0] == PRE0) && r_open))
        else $error("job start did not load its four header bytes");
`endif

endmodule

FILE: dv/tx_packet_framer_crc5_crc16_tb.sv
// Self-checking testbench for tx_packet_framer_crc5_crc16: builds command and job
// packets, predicts every outgoing byte and CRC, and checks the byte stream.
// Depends on txpf_pkg and the framer RTL.
`timescale 1ns / 1ps

import txpf_pkg::*;

class framer_scoreboard;
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       eop;
    } t_beat;

    logic [7:0]  type_bits;
    logic [7:0]  job_hdr;
    bit          pkt_open;
    bit          is_job;
    logic [7:0]  left;
    logic [15:0] crc;
    t_beat       expected_q[$];
    int          errors;

    function new();
        type_bits = CMD_TYPE_RESET;
        job_hdr   = JOB_HDR_RESET;
        pkt_open  = 1'b0;
        is_job    = 1'b0;
        left      = '0;
        crc       = '0;
        errors    = 0;
    endfunction

    function void set_reg(input t_reg_idx idx, input logic [7:0] value);
        if (idx == REG_CMD_TYPE)
            type_bits = value;
        else
            job_hdr = value;
    endfunction

    // bit-serial CRC, MSB first; CRC5 lives in the low five bits
    function logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
        logic [4:0] c5;
        logic       fb;
        c5 = c[4:0];
        for (int i = 7; i >= 0; i--) begin
            if (is_job) begin
                fb = c[15] ^ b[i];
                c  = {c[14:0], 1'b0};
                if (fb) c = c ^ CRC16_POLY;
            end else begin
                fb = c5[4] ^ b[i];
                c5 = {c5[3:0], 1'b0};
                if (fb) c5 = c5 ^ CRC5_POLY;
            end
        end
        return is_job ? c : {11'd0, c5};
    endfunction

    function void push(input logic [7:0] b, input logic eop);
        expected_q.push_back('{tx_byte: b, eop: eop});
    endfunction

    function void close_packet();
        if (is_job) begin
            push(crc[15:8], 1'b0);
            push(crc[7:0], 1'b1);
        end else begin
            push({3'd0, crc[4:0]}, 1'b1);
        end
        pkt_open = 1'b0;
        left     = '0;
    endfunction

    // returns the number of bytes this request produces
    function int note_request(input t_in_item it);
        logic [7:0] hdr;
        logic [7:0] len;
        int         before_n;
        before_n = expected_q.size();
        if (it.op == OP_CMD || it.op == OP_JOB) begin
            is_job = (it.op == OP_JOB);
            if (is_job) begin
                hdr  = job_hdr;
                len  = JOB_LEN_BYTE;
                left = JOB_PAYLOAD_CNT;
                crc  = CRC16_INIT;
            end else begin
                hdr  = type_bits | it.group_bits | it.command_code;
                len  = it.payload_length + CMD_LEN_EXTRA;
                left = it.payload_length;
                crc  = {11'd0, CRC5_INIT};
            end
            crc      = crc_update(crc, hdr);
            crc      = crc_update(crc, len);
            pkt_open = 1'b1;
            push(PRE0, 1'b0);
            push(PRE1, 1'b0);
            push(hdr, 1'b0);
            push(len, 1'b0);
            if (left == 0) close_packet();
        end else if (it.op == OP_DATA && pkt_open) begin
            push(it.data_byte, 1'b0);
            crc  = crc_update(crc, it.data_byte);
            left = left - 8'd1;
            if (left == 0) close_packet();
        end
        return expected_q.size() - before_n;
    endfunction

    function void check_byte(input logic [7:0] b, input logic eop);
        t_beat exp_beat;
        if (expected_q.size() == 0) begin
            $error("unexpected byte %0h (tlast %0b)", b, eop);
            errors++;
            return;
        end
        exp_beat = expected_q.pop_front();
        if (b !== exp_beat.tx_byte) begin
            $error("tx_byte: expected %0h, got %0h", exp_beat.tx_byte, b);
            errors++;
        end
        if (eop !== exp_beat.eop) begin
            $error("end_of_packet: expected %0b, got %0b", exp_beat.eop, eop);
            errors++;
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void flush_leftovers();
        if (expected_q.size() != 0) begin
            $error("%0d expected bytes never arrived", expected_q.size());
            errors++;
            expected_q.delete();
        end
    endfunction
endclass

module tx_packet_framer_crc5_crc16_tb;
    localparam logic [1:0] OP_RESERVED   = 2'd3;
    localparam int         HOLD_CYCLES   = 64;
    localparam int         SETTLE_CYCLES = 6;
    localparam int         DRAIN_LIMIT   = 20000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [7:0]  cfg_data  = '0;

    bit tx_idle_on  = 1'b1;
    bit rx_idle_on  = 1'b1;
    bit rx_hold_req = 1'b0;
    int busy_items  = 0;

    framer_scoreboard frames = new();

    tx_packet_framer_crc5_crc16 i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    task automatic send_req(input logic [1:0] op, input logic [7:0] grp, input logic [7:0] cmd,
                            input logic [7:0] plen, input logic [7:0] data);
        t_in_item it;
        int       gap;
        it.op             = op;
        it.group_bits     = grp;
        it.command_code   = cmd;
        it.payload_length = plen;
        it.data_byte      = data;
        gap = tx_idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, it};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (frames.note_request(it) > 0) busy_items++;
    endtask

    task automatic send_packet(input logic [1:0] op, input int plen, input int ndata);
        send_req(op, 8'($urandom), 8'($urandom), 8'(plen), 8'($urandom));
        repeat (ndata)
            send_req(OP_DATA, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic random_traffic(input int target);
        int         stop_at;
        int         pick;
        int         plen;
        int         need;
        logic [1:0] op;
        stop_at = busy_items + target;
        while (busy_items < stop_at) begin
            pick = $urandom_range(0, 99);
            plen = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 6);
            if (pick < 55) begin
                send_packet(OP_CMD, plen, plen);
            end else if (pick < 61) begin
                send_packet(OP_JOB, plen, JOB_PAYLOAD_BYTES);
            end else if (pick < 81) begin
                // packet cut short by the next start
                op   = $urandom_range(0, 1) ? OP_JOB : OP_CMD;
                need = (op == OP_JOB) ? JOB_PAYLOAD_BYTES : plen;
                send_packet(op, plen, (need == 0) ? 0 : $urandom_range(0, need - 1));
            end else begin
                op = $urandom_range(0, 1) ? OP_RESERVED : OP_DATA;
                send_req(op, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            end
        end
    endtask

    task automatic program_regs(input logic [7:0] type_bits, input logic [7:0] job_hdr);
        cfg_valid <= 1'b1;
        for (int r = 0; r < 2; r++) begin
            cfg_index <= (r == 0) ? REG_CMD_TYPE : REG_JOB_HDR;
            cfg_data  <= (r == 0) ? type_bits : job_hdr;
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            frames.set_reg((r == 0) ? REG_CMD_TYPE : REG_JOB_HDR, (r == 0) ? type_bits : job_hdr);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        int n;
        s_tvalid <= 1'b0;
        n = 0;
        while (frames.pending() != 0 && n < DRAIN_LIMIT) begin
            @(posedge clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin : byte_sink
        int gap;
        @(posedge rst_n);
        forever begin
            gap = rx_idle_on ? $urandom_range(0, 3) : 0;
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            frames.check_byte(m_tdata, m_tlast);
        end
    end

    initial begin : stimulus
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset register values
        send_req(OP_CMD, 8'h00, 8'h00, 8'd0, 8'h00);
        send_req(OP_CMD, 8'hFF, 8'hFF, 8'd0, 8'hFF);
        send_req(OP_DATA, 8'h00, 8'h00, 8'h00, 8'hFF);
        send_req(OP_RESERVED, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_req(OP_CMD, 8'h12, 8'h03, 8'd2, 8'h00);
        send_req(OP_DATA, 8'hFF, 8'hFF, 8'hFF, 8'h00);
        send_req(OP_DATA, 8'h00, 8'h00, 8'h00, 8'hFF);
        // length byte wraps, then abandoned by a job start
        send_req(OP_CMD, 8'hA5, 8'h5A, 8'd255, 8'h00);
        send_req(OP_DATA, 8'h00, 8'h00, 8'h00, 8'h81);
        send_req(OP_JOB, 8'h00, 8'h00, 8'h00, 8'h00);
        send_req(OP_DATA, 8'h00, 8'h00, 8'h00, 8'h00);
        send_req(OP_DATA, 8'h00, 8'h00, 8'h00, 8'hFF);
        send_req(OP_DATA, 8'h00, 8'h00, 8'h00, 8'h3C);
        send_req(OP_CMD, 8'h00, 8'h00, 8'd252, 8'h00);
        send_req(OP_DATA, 8'h00, 8'h00, 8'h00, 8'h7E);
        send_req(OP_CMD, 8'h01, 8'h80, 8'd1, 8'h00);
        send_req(OP_DATA, 8'h00, 8'h00, 8'h00, 8'hC3);
        send_req(OP_CMD, 8'h04, 8'h20, 8'd1, 8'h00);
        send_req(OP_RESERVED, 8'h00, 8'h00, 8'h00, 8'h00);
        send_req(OP_DATA, 8'h00, 8'h00, 8'h00, 8'h5A);
        settle();

        program_regs(8'h00, 8'h00);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_packet(OP_JOB, 0, JOB_PAYLOAD_BYTES);
        random_traffic(20);
        settle();

        program_regs(8'hFF, 8'hFF);
        tx_idle_on  = 1'b1;
        rx_idle_on  = 1'b1;
        rx_hold_req = 1'b1;
        send_packet(OP_CMD, 30, 30);
        random_traffic(20);
        settle();

        program_regs(8'($urandom), 8'($urandom));
        random_traffic(20);
        settle();

        frames.flush_leftovers();
        if (frames.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin : watchdog
        #(5_000_000);
        $display("Some tests failed");
        $finish;
    end
endmodule

FILE: files.f
hdl/txpf_pkg.sv
hdl/tx_packet_framer_crc5_crc16.sv
dv/tx_packet_framer_crc5_crc16_tb.sv
